// ===== rtl/sm3_hash_engine_core_macros.svh =====
// Assertion macros for the SM3 hash engine core.
// Included by sm3_hash_engine_core.sv; no other dependencies.
`ifndef SM3_HASH_ENGINE_CORE_MACROS_SVH
`define SM3_HASH_ENGINE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SM3_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SM3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sm3_pkg.sv =====
// SM3 hash engine package: payload structs and algorithm constants.
// No dependencies.
package sm3_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  valid_bytes;
        logic        last_word;
    } msg_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        digest_last;
    } dig_t;

    localparam logic [31:0] IV [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    localparam logic [31:0] T_LOW    = 32'h79cc4519;
    localparam logic [31:0] T_HIGH   = 32'h7a879d8a;
    localparam logic [31:0] T_HIGH16 = {T_HIGH[15:0], T_HIGH[31:16]};
    localparam logic [31:0] PAD_WORD = {8'h80, 24'h000000};
    localparam logic [3:0]  LEN_SLOT = 4'd14;
    localparam logic [2:0]  FULL_BYTES = 3'd4;

endpackage

// ===== rtl/sm3_hash_engine_core.sv =====
// SM3 hash engine: 16-word message window, one compression round per cycle, padding
// sequencer and digest output. Words enter the window until a block fills, then the
// 64 rounds and a fold run; the final word is followed by padding words and one or two
// compressions before 8 digest transfers. No message word is accepted while rounds,
// fold, padding or digest output run. Reset (async, rst_n low) loads the IV and clears
// counters; the message window needs no clearing.
// Depends on sm3_pkg and sm3_hash_engine_core_macros.svh.
`include "sm3_hash_engine_core_macros.svh"

module sm3_hash_engine_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          msg_valid,
    output logic          msg_ready,
    input  sm3_pkg::msg_t msg,
    output logic          dig_valid,
    input  logic          dig_ready,
    output sm3_pkg::dig_t dig
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        rotl = (x << n) | (x >> (6'd32 - {1'b0, n}));
    endfunction

    function automatic logic [31:0] p0(input logic [31:0] x);
        p0 = x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] p1(input logic [31:0] x);
        p1 = x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

    logic [2:0]  state_reg, state_next;
    logic [3:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [5:0]  round_reg, round_next;
    logic [31:0] tj_reg, tj_next;
    logic [2:0]  idx_reg, idx_next;
    logic        pad_active_reg, pad_active_next;
    logic        pad80_reg, pad80_next;
    logic        hi_done_reg, hi_done_next;
    logic        len_done_reg, len_done_next;
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    logic [31:0] work_reg [8];
    logic [31:0] work_next [8];

    logic        push_en;
    logic [31:0] push_word;
    logic [2:0]  count;
    logic [31:0] last_word_val;
    logic [31:0] a12, ss1, ss2, fv, gv, tt1, tt2, w_new;

    always_comb
    begin
        if (!msg.last_word || msg.valid_bytes > sm3_pkg::FULL_BYTES)
            count = sm3_pkg::FULL_BYTES;
        else
            count = msg.valid_bytes;
        unique case (count)
            3'd0:    last_word_val = sm3_pkg::PAD_WORD;
            3'd1:    last_word_val = {msg.message_word[31:24], 8'h80, 16'h0000};
            3'd2:    last_word_val = {msg.message_word[31:16], 8'h80, 8'h00};
            3'd3:    last_word_val = {msg.message_word[31:8], 8'h80};
            default: last_word_val = msg.message_word;
        endcase
    end

    always_comb
    begin
        a12   = rotl(work_reg[0], 5'd12);
        ss1   = rotl(a12 + work_reg[4] + tj_reg, 5'd7);
        ss2   = ss1 ^ a12;
        if (round_reg < 6'd16)
        begin
            fv = work_reg[0] ^ work_reg[1] ^ work_reg[2];
            gv = work_reg[4] ^ work_reg[5] ^ work_reg[6];
        end
        else
        begin
            fv = (work_reg[0] & work_reg[1]) | (work_reg[0] & work_reg[2])
                 | (work_reg[1] & work_reg[2]);
            gv = (work_reg[4] & work_reg[5]) | (~work_reg[4] & work_reg[6]);
        end
        tt1   = fv + work_reg[3] + ss2 + (win_reg[0] ^ win_reg[4]);
        tt2   = gv + work_reg[7] + ss1 + win_reg[0];
        w_new = p1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 5'd15))
                ^ rotl(win_reg[3], 5'd7) ^ win_reg[10];
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        bits_next       = bits_reg;
        round_next      = round_reg;
        tj_next         = tj_reg;
        idx_next        = idx_reg;
        pad_active_next = pad_active_reg;
        pad80_next      = pad80_reg;
        hi_done_next    = hi_done_reg;
        len_done_next   = len_done_reg;
        chain_next      = chain_reg;
        win_next        = win_reg;
        work_next       = work_reg;
        push_en         = 1'b0;
        push_word       = msg.message_word;
        msg_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                msg_ready = 1'b1;
                if (msg_valid)
                begin
                    push_en   = 1'b1;
                    bits_next = bits_reg + 64'({count, 3'b000});
                    if (msg.last_word)
                    begin
                        push_word       = last_word_val;
                        pad_active_next = 1'b1;
                        pad80_next      = (count == sm3_pkg::FULL_BYTES);
                        state_next      = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                priority if (pad80_reg)
                begin
                    push_word  = sm3_pkg::PAD_WORD;
                    pad80_next = 1'b0;
                end
                else if (hi_done_reg)
                begin
                    push_word     = bits_reg[31:0];
                    len_done_next = 1'b1;
                end
                else if (fill_reg == sm3_pkg::LEN_SLOT)
                begin
                    push_word    = bits_reg[63:32];
                    hi_done_next = 1'b1;
                end
                else
                begin
                    push_word = 32'h0;
                end
            end
            ST_ROUND:
            begin
                work_next[0] = tt1;
                work_next[1] = work_reg[0];
                work_next[2] = rotl(work_reg[1], 5'd9);
                work_next[3] = work_reg[2];
                work_next[4] = p0(tt2);
                work_next[5] = work_reg[4];
                work_next[6] = rotl(work_reg[5], 5'd19);
                work_next[7] = work_reg[6];
                for (int i = 0; i < 15; i++)
                    win_next[i] = win_reg[i + 1];
                win_next[15] = w_new;
                round_next   = round_reg + 6'd1;
                if (round_reg == 6'd15)
                    tj_next = sm3_pkg::T_HIGH16;
                else
                    tj_next = rotl(tj_reg, 5'd1);
                if (round_reg == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                for (int i = 0; i < 8; i++)
                    chain_next[i] = chain_reg[i] ^ work_reg[i];
                priority if (pad_active_reg && len_done_reg)
                begin
                    idx_next   = 3'd0;
                    state_next = ST_OUT;
                end
                else if (pad_active_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:
            begin
                if (dig_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        chain_next      = sm3_pkg::IV;
                        fill_next       = 4'd0;
                        bits_next       = 64'd0;
                        pad_active_next = 1'b0;
                        pad80_next      = 1'b0;
                        hi_done_next    = 1'b0;
                        len_done_next   = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push_en)
        begin
            for (int i = 0; i < 15; i++)
                win_next[i] = win_reg[i + 1];
            win_next[15] = push_word;
            if (fill_reg == 4'd15)
            begin
                fill_next  = 4'd0;
                work_next  = chain_reg;
                round_next = 6'd0;
                tj_next    = sm3_pkg::T_LOW;
                state_next = ST_ROUND;
            end
            else
                fill_next = fill_reg + 4'd1;
        end
    end

    assign dig_valid        = (state_reg == ST_OUT);
    assign dig.digest_word  = chain_reg[idx_reg];
    assign dig.digest_index = idx_reg;
    assign dig.digest_last  = (idx_reg == 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_reg       <= 4'd0;
            bits_reg       <= 64'd0;
            round_reg      <= 6'd0;
            tj_reg         <= sm3_pkg::T_LOW;
            idx_reg        <= 3'd0;
            pad_active_reg <= 1'b0;
            pad80_reg      <= 1'b0;
            hi_done_reg    <= 1'b0;
            len_done_reg   <= 1'b0;
            chain_reg      <= sm3_pkg::IV;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            bits_reg       <= bits_next;
            round_reg      <= round_next;
            tj_reg         <= tj_next;
            idx_reg        <= idx_next;
            pad_active_reg <= pad_active_next;
            pad80_reg      <= pad80_next;
            hi_done_reg    <= hi_done_next;
            len_done_reg   <= len_done_next;
            chain_reg      <= chain_next;
        end
    end

    always_ff @(posedge clk)
    begin
        win_reg  <= win_next;
        work_reg <= work_next;
    end

    `SM3_ASSERT_NOW(a_ready_excl, clk, rst_n, msg_ready, !dig_valid, "ready during digest output")
    `SM3_ASSERT_NOW(a_round_state, clk, rst_n, round_reg != 6'd0, state_reg == ST_ROUND, "round counter active outside rounds")
    `SM3_ASSERT_NOW(a_out_fill, clk, rst_n, state_reg == ST_OUT, fill_reg == 4'd0 && len_done_reg, "digest output with partial block")
    `SM3_ASSERT_NEXT(a_last_fold, clk, rst_n, state_reg == ST_ROUND && round_reg == 6'd63, state_reg == ST_FOLD, "missing fold after final round")
    `SM3_ASSERT_NEXT(a_digest_done, clk, rst_n, dig_valid && dig_ready && dig.digest_last, state_reg == ST_IDLE && chain_reg[0] == sm3_pkg::IV[0] && bits_reg == 64'd0, "state not restored after digest")

endmodule
